[src/dcw_pkg.sv]
package dcw_pkg;

	localparam int unsigned NsPerS = 1000000000;

	localparam logic [2:0] AddrTimeCut = 3'd0;
	localparam logic [2:0] AddrPosCut = 3'd4;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_STORE,
		ST_RD_OLD,
		ST_WAIT_OLD,
		ST_DSQ,
		ST_TEST,
		ST_DIST,
		ST_SQRT,
		ST_SQRT_WAIT,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic store;
		logic rd_old;
		logic load_old;
		logic dsq_start;
		logic drop;
		logic pair_start;
		logic [2:0] dist_sel;
		logic dist_load;
		logic sqrt_start;
		logic sqrt_save;
		logic out_multi;
	} dcw_cmd_t;

	typedef struct packed {
		logic keep;
		logic sqrt_done;
	} dcw_stat_t;

	typedef struct packed {
		logic [31:0] sec;
		logic [29:0] ns;
		logic [15:0] pe;
		logic signed [15:0] dx;
		logic signed [15:0] dy;
		logic signed [15:0] dz;
		logic signed [15:0] ox;
		logic signed [15:0] oy;
		logic signed [15:0] oz;
	} entry_t;

	typedef struct packed {
		logic status;
		logic [15:0] prompt_pe;
		logic [15:0] delayed_pe;
		logic [29:0] gap_ns;
		logic [16:0] pair_distance;
		logic [16:0] prompt_spread;
		logic [16:0] origin_drift;
		logic [16:0] delayed_to_origin;
		logic [16:0] delayed_spread;
	} result_t;

	// squared distance; each axis difference fits 16 bits in magnitude
	function automatic logic [33:0] dsq3(input logic signed [15:0] a0, a1, a2,
		input logic signed [15:0] b0, b1, b2);
		logic signed [16:0] d0, d1, d2;
		logic [15:0] m0, m1, m2;
		logic [31:0] p0, p1, p2;
		begin
			d0 = 17'(a0) - 17'(b0);
			d1 = 17'(a1) - 17'(b1);
			d2 = 17'(a2) - 17'(b2);
			m0 = d0[16] ? 16'(-d0) : 16'(d0);
			m1 = d1[16] ? 16'(-d1) : 16'(d1);
			m2 = d2[16] ? 16'(-d2) : 16'(d2);
			p0 = 32'(m0) * 32'(m0);
			p1 = 32'(m1) * 32'(m1);
			p2 = 32'(m2) * 32'(m2);
			dsq3 = 34'(p0) + 34'(p1) + 34'(p2);
		end
	endfunction

endpackage

[src/dcw_if.sv]
interface dcw_in_if;
	logic valid;
	logic ready;
	logic [31:0] event_seconds;
	logic [29:0] event_nanos;
	logic [15:0] total_pe;
	logic signed [15:0] deposit_x;
	logic signed [15:0] deposit_y;
	logic signed [15:0] deposit_z;
	logic signed [15:0] origin_x;
	logic signed [15:0] origin_y;
	logic signed [15:0] origin_z;
	modport source(output valid, event_seconds, event_nanos, total_pe, deposit_x, deposit_y,
		deposit_z, origin_x, origin_y, origin_z, input ready);
	modport sink(input valid, event_seconds, event_nanos, total_pe, deposit_x, deposit_y,
		deposit_z, origin_x, origin_y, origin_z, output ready);
endinterface

interface dcw_out_if;
	logic valid;
	logic ready;
	logic status;
	logic [15:0] prompt_pe;
	logic [15:0] delayed_pe;
	logic [29:0] gap_ns;
	logic [16:0] pair_distance;
	logic [16:0] prompt_spread;
	logic [16:0] origin_drift;
	logic [16:0] delayed_to_origin;
	logic [16:0] delayed_spread;
	modport source(output valid, status, prompt_pe, delayed_pe, gap_ns, pair_distance,
		prompt_spread, origin_drift, delayed_to_origin, delayed_spread, input ready);
	modport sink(input valid, status, prompt_pe, delayed_pe, gap_ns, pair_distance,
		prompt_spread, origin_drift, delayed_to_origin, delayed_spread, output ready);
endinterface

[src/dcw_isqrt.sv]
// bit-serial integer square root, one result bit per cycle
module dcw_isqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [33:0] radicand,
	output logic        done,
	output logic [16:0] root
);
	logic [33:0] rem_q;
	logic [33:0] val_q;
	logic [16:0] root_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic [33:0] trial;
	logic [33:0] rem_sh;

	always_comb begin
		rem_sh = {rem_q[31:0], val_q[33:32]};
		trial  = {15'd0, root_q, 2'b01};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'd17;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			val_q  <= radicand;
			root_q <= '0;
		end else if (busy_q) begin
			val_q <= {val_q[31:0], 2'b00};
			if (rem_sh >= trial) begin
				rem_q  <= rem_sh - trial;
				root_q <= {root_q[15:0], 1'b1};
			end else begin
				rem_q  <= rem_sh;
				root_q <= {root_q[15:0], 1'b0};
			end
		end
	end

	assign root = root_q;
endmodule

[src/dcw_datapath.sv]
module dcw_datapath #(
	parameter int WINDOW_DEPTH = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  dcw_pkg::dcw_cmd_t   cmd,
	output dcw_pkg::dcw_stat_t  stat,
	input  dcw_pkg::entry_t     in_entry,
	input  logic [29:0]         time_cut_ns,
	input  logic [15:0]         pos_cut_mm,
	output logic [$clog2(WINDOW_DEPTH+1)-1:0] count,
	output dcw_pkg::result_t    res
);
	localparam int AW = $clog2(WINDOW_DEPTH);
	localparam int CW = $clog2(WINDOW_DEPTH + 1);

	dcw_pkg::entry_t mem [WINDOW_DEPTH];
	dcw_pkg::entry_t new_q, old_q, rd_q;
	logic [AW-1:0] oldest_q;
	logic [CW-1:0] count_q;
	logic [33:0] dsq_q, cutsq_q, rad_q;
	logic signed [32:0] ds_q;
	logic signed [31:0] dn_q;
	logic [16:0] root;
	logic sqdone;
	logic [AW-1:0] wr_slot;
	logic [AW:0] wr_sum;
	logic [AW:0] old_next;
	logic signed [32:0] ds_w;
	logic signed [31:0] dn_w;
	logic [33:0] dist_w;
	dcw_pkg::result_t res_q;

	always_comb begin
		wr_sum = {1'b0, oldest_q} + (AW+1)'(count_q);
		wr_slot = (wr_sum >= (AW+1)'(WINDOW_DEPTH)) ?
			AW'(wr_sum - (AW+1)'(WINDOW_DEPTH)) : AW'(wr_sum);
		old_next = {1'b0, oldest_q} + (AW+1)'(1);
		ds_w = 33'(new_q.sec) - 33'(old_q.sec);
		dn_w = 32'(new_q.ns) - 32'(old_q.ns);
		if (dn_w < 0) begin
			dn_w = dn_w + 32'(dcw_pkg::NsPerS);
			ds_w = ds_w - 33'sd1;
		end
		unique case (cmd.dist_sel)
			3'd0: dist_w = dcw_pkg::dsq3(old_q.dx, old_q.dy, old_q.dz,
				new_q.dx, new_q.dy, new_q.dz);
			3'd1: dist_w = dcw_pkg::dsq3(old_q.dx, old_q.dy, old_q.dz,
				old_q.ox, old_q.oy, old_q.oz);
			3'd2: dist_w = dcw_pkg::dsq3(old_q.ox, old_q.oy, old_q.oz,
				new_q.ox, new_q.oy, new_q.oz);
			3'd3: dist_w = dcw_pkg::dsq3(new_q.dx, new_q.dy, new_q.dz,
				old_q.ox, old_q.oy, old_q.oz);
			default: dist_w = dcw_pkg::dsq3(new_q.dx, new_q.dy, new_q.dz,
				new_q.ox, new_q.oy, new_q.oz);
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.store) begin
			mem[wr_slot] <= in_entry;
			new_q <= in_entry;
		end
		if (cmd.rd_old) rd_q <= mem[oldest_q];
		if (cmd.load_old) old_q <= rd_q;
		if (cmd.dsq_start) begin
			dsq_q <= dist_w;
			ds_q <= ds_w;
			dn_q <= dn_w;
			cutsq_q <= 34'(32'(pos_cut_mm) * 32'(pos_cut_mm));
		end
		if (cmd.dist_load) rad_q <= dist_w;
		if (cmd.pair_start) begin
			res_q.status <= 1'b0;
			res_q.prompt_pe <= old_q.pe;
			res_q.delayed_pe <= new_q.pe;
			res_q.gap_ns <= dn_q[29:0];
		end
		if (cmd.sqrt_save) begin
			unique case (cmd.dist_sel)
				3'd0: res_q.pair_distance <= root;
				3'd1: res_q.prompt_spread <= root;
				3'd2: res_q.origin_drift <= root;
				3'd3: res_q.delayed_to_origin <= root;
				default: res_q.delayed_spread <= root;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oldest_q <= '0;
			count_q <= '0;
		end else if (cmd.store) begin
			if (count_q == CW'(WINDOW_DEPTH)) begin
				oldest_q <= (old_next == (AW+1)'(WINDOW_DEPTH)) ? '0 : AW'(old_next);
			end else begin
				count_q <= count_q + CW'(1);
			end
		end else if (cmd.drop) begin
			oldest_q <= (old_next == (AW+1)'(WINDOW_DEPTH)) ? '0 : AW'(old_next);
			count_q <= count_q - CW'(1);
		end
	end

	dcw_isqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(cmd.sqrt_start), .radicand(rad_q),
		.done(sqdone), .root(root)
	);

	always_comb begin
		stat.keep = (ds_q == 33'sd0) && (dn_q <= 32'(time_cut_ns)) && (dsq_q <= cutsq_q);
		stat.sqrt_done = sqdone;
		res = res_q;
		if (cmd.out_multi) begin
			res = '0;
			res.status = 1'b1;
		end
	end

	assign count = count_q;
endmodule

[src/dcw_ctrl.sv]
module dcw_ctrl #(
	parameter int WINDOW_DEPTH = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  logic [$clog2(WINDOW_DEPTH+1)-1:0] count,
	input  dcw_pkg::dcw_stat_t stat,
	output dcw_pkg::dcw_cmd_t  cmd
);
	localparam int CW = $clog2(WINDOW_DEPTH + 1);

	dcw_pkg::state_t state_q, state_d;
	logic [2:0] sel_q;
	logic multi_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			dcw_pkg::ST_IDLE: if (in_valid) state_d = dcw_pkg::ST_STORE;
			dcw_pkg::ST_STORE: state_d = dcw_pkg::ST_RD_OLD;
			dcw_pkg::ST_RD_OLD: state_d = (count > CW'(1)) ? dcw_pkg::ST_WAIT_OLD
				: dcw_pkg::ST_IDLE;
			dcw_pkg::ST_WAIT_OLD: state_d = dcw_pkg::ST_DSQ;
			dcw_pkg::ST_DSQ: state_d = dcw_pkg::ST_TEST;
			dcw_pkg::ST_TEST: begin
				if (!stat.keep) state_d = dcw_pkg::ST_RD_OLD;
				else if (count > CW'(2)) state_d = dcw_pkg::ST_OUT;
				else state_d = dcw_pkg::ST_DIST;
			end
			dcw_pkg::ST_DIST: state_d = dcw_pkg::ST_SQRT;
			dcw_pkg::ST_SQRT: state_d = dcw_pkg::ST_SQRT_WAIT;
			dcw_pkg::ST_SQRT_WAIT: if (stat.sqrt_done)
				state_d = (sel_q == 3'd4) ? dcw_pkg::ST_OUT : dcw_pkg::ST_DIST;
			dcw_pkg::ST_OUT: if (out_ready) state_d = dcw_pkg::ST_IDLE;
			default: state_d = dcw_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.dist_sel = sel_q;
		cmd.out_multi = multi_q;
		in_ready = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			dcw_pkg::ST_IDLE: in_ready = 1'b1;
			dcw_pkg::ST_STORE: cmd.store = 1'b0;
			dcw_pkg::ST_RD_OLD: cmd.rd_old = 1'b1;
			dcw_pkg::ST_WAIT_OLD: cmd.load_old = 1'b1;
			dcw_pkg::ST_DSQ: begin
				cmd.dsq_start = 1'b1;
				cmd.dist_sel = 3'd0;
			end
			dcw_pkg::ST_TEST: begin
				cmd.drop = !stat.keep;
				cmd.pair_start = stat.keep;
			end
			dcw_pkg::ST_DIST: cmd.dist_load = 1'b1;
			dcw_pkg::ST_SQRT: cmd.sqrt_start = 1'b1;
			dcw_pkg::ST_SQRT_WAIT: cmd.sqrt_save = stat.sqrt_done;
			dcw_pkg::ST_OUT: out_valid = 1'b1;
			default: ;
		endcase
		cmd.store = (state_q == dcw_pkg::ST_IDLE) && in_valid;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dcw_pkg::ST_IDLE;
			sel_q <= '0;
			multi_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == dcw_pkg::ST_TEST) begin
				sel_q <= '0;
				multi_q <= count > CW'(2);
			end else if (state_q == dcw_pkg::ST_SQRT_WAIT && stat.sqrt_done)
				sel_q <= sel_q + 3'd1;
		end
	end
endmodule

[src/delayed_coincidence_window.sv]
// Delayed coincidence window. Each accepted event is stored in a ring of WINDOW_DEPTH
// entries; stale entries are dropped from the oldest side one at a time, each after a
// memory read, a load, one distance/time evaluation and the test. A pair result runs five
// bit-serial square roots in turn, each with an operand load, a start and a wait for done;
// an event that leaves one entry ends without a result, and a multiple status skips the
// square roots. A stalled result holds the input off. One event at a time is processed.
// Registers: 0x0 time_cut_ns, 0x4 pos_cut_mm.
module delayed_coincidence_window #(
	parameter int WINDOW_DEPTH = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	dcw_in_if.sink      in_ch,
	dcw_out_if.source   out_ch,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	localparam int CW = $clog2(WINDOW_DEPTH + 1);

	logic [29:0] time_cut_q;
	logic [15:0] pos_cut_q;
	dcw_pkg::dcw_cmd_t cmd;
	dcw_pkg::dcw_stat_t stat;
	dcw_pkg::entry_t in_entry;
	dcw_pkg::result_t res;
	logic [CW-1:0] count;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_cut_q <= 30'd800000;
			pos_cut_q <= 16'd3000;
		end else if (psel && penable && pwrite) begin
			if (paddr == dcw_pkg::AddrTimeCut) time_cut_q <= pwdata[29:0];
			else if (paddr == dcw_pkg::AddrPosCut) pos_cut_q <= pwdata[15:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr == dcw_pkg::AddrTimeCut) prdata = {2'b00, time_cut_q};
		else if (paddr == dcw_pkg::AddrPosCut) prdata = {16'd0, pos_cut_q};
	end

	assign in_entry = '{sec: in_ch.event_seconds, ns: in_ch.event_nanos, pe: in_ch.total_pe,
		dx: in_ch.deposit_x, dy: in_ch.deposit_y, dz: in_ch.deposit_z,
		ox: in_ch.origin_x, oy: in_ch.origin_y, oz: in_ch.origin_z};

	dcw_ctrl #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready), .count(count),
		.stat(stat), .cmd(cmd)
	);

	dcw_datapath #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat), .in_entry(in_entry),
		.time_cut_ns(time_cut_q), .pos_cut_mm(pos_cut_q), .count(count), .res(res)
	);

	assign out_ch.status = res.status;
	assign out_ch.prompt_pe = res.prompt_pe;
	assign out_ch.delayed_pe = res.delayed_pe;
	assign out_ch.gap_ns = res.gap_ns;
	assign out_ch.pair_distance = res.pair_distance;
	assign out_ch.prompt_spread = res.prompt_spread;
	assign out_ch.origin_drift = res.origin_drift;
	assign out_ch.delayed_to_origin = res.delayed_to_origin;
	assign out_ch.delayed_spread = res.delayed_spread;

	a_no_in_while_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> !in_ch.ready) else $error("input taken while result pending");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count <= CW'(WINDOW_DEPTH)) else $error("window count overflow");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |=> out_ch.valid) else $error("result dropped");
endmodule
